// ===== rtl/core/mplc_pkg.sv =====
// shared types, register codes and helper functions for the mecanum power limited current block
// no dependencies
package mplc_pkg;

    localparam int WHEELS = 4;
    localparam int IDX_W = $clog2(WHEELS);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_SUM_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_BUDGET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_THRESHOLD = 3'd3;

    localparam logic [14:0] SPEED_LIMIT_RST = 15'd6000;
    localparam logic [16:0] ERROR_SUM_LIMIT_RST = 17'd24000;
    localparam logic [16:0] CURRENT_BUDGET_RST = 17'd61536;
    localparam logic [11:0] POWER_THRESHOLD_RST = 12'd600;

    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 18;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    typedef struct packed {
        logic             in_ready;
        logic             mix;
        logic             lim_start;
        logic             lim_store;
        logic             err;
        logic             mul;
        logic             cur_start;
        logic             cur_store;
        logic             zero_cur;
        logic             out_load;
        logic             hold;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic over_power;
        logic over_limit;
        logic sum_zero;
        logic div_done;
        logic out_free;
    } dp_sts_t;

    // buffer energy band to q1.16 scale factor
    function automatic logic [16:0] buffer_factor(input logic signed [8:0] b);
        logic [16:0] f;
        begin
            if (b >= 9'sd40 && b < 9'sd50)
                f = 17'd58982;
            else if (b >= 9'sd35 && b < 9'sd40)
                f = 17'd49152;
            else if (b >= 9'sd30 && b < 9'sd35)
                f = 17'd32768;
            else if (b >= 9'sd20 && b < 9'sd30)
                f = 17'd16384;
            else if (b >= 9'sd10 && b < 9'sd20)
                f = 17'd8192;
            else if (b >= 9'sd0 && b < 9'sd10)
                f = 17'd3277;
            else
                f = 17'd65536;
            return f;
        end
    endfunction

    function automatic logic [16:0] mag18(input logic signed [17:0] v);
        logic signed [17:0] n;
        begin
            n = -v;
            return v[17] ? n[16:0] : v[16:0];
        end
    endfunction

endpackage

// ===== rtl/core/mplc_in_if.sv =====
// input item channel: chassis commands, wheel speeds, power and buffer energy
// depends on nothing
interface mplc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] speed_lf;
    logic signed [15:0] speed_rf;
    logic signed [15:0] speed_rb;
    logic signed [15:0] speed_lb;
    logic [11:0]        chassis_power;
    logic signed [8:0]  buffer_energy;

    modport source (output valid, vel_x, vel_y, rot_z, speed_lf, speed_rf, speed_rb, speed_lb,
                    chassis_power, buffer_energy, input ready);
    modport sink (input valid, vel_x, vel_y, rot_z, speed_lf, speed_rf, speed_rb, speed_lb,
                  chassis_power, buffer_energy, output ready);
endinterface

// ===== rtl/core/mplc_out_if.sv =====
// result item channel: four wheel currents and the power held flag
// depends on nothing
interface mplc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] current_lf;
    logic signed [15:0] current_rf;
    logic signed [15:0] current_rb;
    logic signed [15:0] current_lb;
    logic               power_held;

    modport source (output valid, current_lf, current_rf, current_rb, current_lb, power_held,
                    input ready);
    modport sink (input valid, current_lf, current_rf, current_rb, current_lb, power_held,
                  output ready);
endinterface

// ===== rtl/core/mplc_cfg_if.sv =====
// configuration write channel: register index and write data
// uses mplc_pkg for widths
interface mplc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mplc_pkg::CFG_IDX_W-1:0]  index;
    logic [mplc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mplc_divider.sv =====
// restoring divider, one quotient bit per cycle, shared by speed limit and current steps
// uses mplc_pkg for widths
module mplc_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mplc_pkg::DIV_NUM_W-1:0] num,
    input  logic [mplc_pkg::DIV_DEN_W-1:0] den,
    output logic [mplc_pkg::DIV_NUM_W-1:0] quo,
    output logic                            done
);

    logic [mplc_pkg::DIV_NUM_W-1:0] quo_reg;
    logic [mplc_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [mplc_pkg::DIV_DEN_W-1:0] den_reg;
    logic [mplc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            done_reg;
    logic [mplc_pkg::DIV_DEN_W:0]   trial;
    logic [mplc_pkg::DIV_DEN_W:0]   diff;
    logic                            ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[mplc_pkg::DIV_NUM_W-1]};
        diff = trial - {1'b0, den_reg};
        ge = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg <= mplc_pkg::DIV_CNT_W'(mplc_pkg::DIV_NUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == mplc_pkg::DIV_CNT_W'(1))
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[mplc_pkg::DIV_DEN_W-1:0] : trial[mplc_pkg::DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[mplc_pkg::DIV_NUM_W-2:0], ge};
        end
    end

    assign quo = quo_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/mplc_datapath.sv =====
// datapath: config registers, wheel mixing, speed limit, error sums, current scaling, output
// uses mplc_pkg, the channel interfaces and mplc_divider
module mplc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    mplc_in_if.sink           in_ch,
    mplc_out_if.source        out_ch,
    mplc_cfg_if.sink          cfg_ch,
    input  mplc_pkg::dp_cmd_t cmd,
    output mplc_pkg::dp_sts_t sts
);

    logic [14:0] speed_limit_reg;
    logic [16:0] error_sum_limit_reg;
    logic [16:0] current_budget_reg;
    logic [11:0] power_threshold_reg;

    logic signed [15:0] vel_x_reg;
    logic signed [15:0] vel_y_reg;
    logic signed [15:0] rot_z_reg;
    logic signed [15:0] speed_reg [mplc_pkg::WHEELS];
    logic [11:0]        power_reg;
    logic signed [8:0]  energy_reg;

    logic signed [17:0] tgt_reg [mplc_pkg::WHEELS];
    logic [16:0]        max_reg;
    logic signed [17:0] err_reg [mplc_pkg::WHEELS];
    logic [17:0]        sum_reg;
    logic [32:0]        prod_reg;
    logic signed [15:0] held_reg [mplc_pkg::WHEELS];

    logic signed [15:0] out_cur_reg [mplc_pkg::WHEELS];
    logic               out_held_reg;
    logic               out_valid_reg;

    logic signed [17:0] xs, ys, zs;
    logic signed [17:0] mix_tgt [mplc_pkg::WHEELS];
    logic [16:0]        mix_max;
    logic signed [17:0] err_next [mplc_pkg::WHEELS];
    logic [17:0]        sum_next;
    logic [31:0]        lim_prod;
    logic [49:0]        cur_full;
    logic [17:0]        cur_den;
    logic [mplc_pkg::DIV_NUM_W-1:0] div_num;
    logic [mplc_pkg::DIV_DEN_W-1:0] div_den;
    logic [mplc_pkg::DIV_NUM_W-1:0] div_quo;
    logic               div_done;
    logic signed [17:0] lim_q;
    logic signed [17:0] lim_val;
    logic [15:0]        pos_val;
    logic [16:0]        neg_mag;
    logic [16:0]        neg_full;
    logic [15:0]        cur_val;
    logic signed [17:0] tgt_sel;
    logic signed [17:0] err_sel;
    logic [16:0]        err_mag_sel;

    // config writes
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= mplc_pkg::SPEED_LIMIT_RST;
            error_sum_limit_reg <= mplc_pkg::ERROR_SUM_LIMIT_RST;
            current_budget_reg <= mplc_pkg::CURRENT_BUDGET_RST;
            power_threshold_reg <= mplc_pkg::POWER_THRESHOLD_RST;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                mplc_pkg::REG_SPEED_LIMIT:     speed_limit_reg <= cfg_ch.data[14:0];
                mplc_pkg::REG_ERROR_SUM_LIMIT: error_sum_limit_reg <= cfg_ch.data;
                mplc_pkg::REG_CURRENT_BUDGET:  current_budget_reg <= cfg_ch.data;
                mplc_pkg::REG_POWER_THRESHOLD: power_threshold_reg <= cfg_ch.data[11:0];
                default: ;
            endcase
        end
    end

    // wheel mixing and magnitudes
    always_comb
    begin
        xs = 18'(vel_x_reg);
        ys = 18'(vel_y_reg);
        zs = 18'(rot_z_reg);
        mix_tgt[0] = xs + ys + zs;
        mix_tgt[1] = xs - ys + zs;
        mix_tgt[2] = zs - ys - xs;
        mix_tgt[3] = ys - xs + zs;
        mix_max = '0;
        for (int i = 0; i < mplc_pkg::WHEELS; i++)
        begin
            if (mplc_pkg::mag18(mix_tgt[i]) > mix_max)
                mix_max = mplc_pkg::mag18(mix_tgt[i]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < mplc_pkg::WHEELS; i++)
        begin
            err_next[i] = tgt_reg[i] - 18'(speed_reg[i]);
            sum_next = sum_next + 18'(mplc_pkg::mag18(err_next[i]));
        end
    end

    // divider operands
    always_comb
    begin
        tgt_sel = tgt_reg[cmd.idx];
        err_sel = err_reg[cmd.idx];
        err_mag_sel = mplc_pkg::mag18(err_sel);
        lim_prod = 32'(mplc_pkg::mag18(tgt_sel)) * 32'(speed_limit_reg);
        cur_full = 50'(prod_reg) * 50'(mplc_pkg::buffer_factor(energy_reg));
        cur_den = (sum_reg >= 18'(error_sum_limit_reg)) ? sum_reg : 18'(error_sum_limit_reg);
        div_num = cmd.cur_start ? cur_full[49:16] : mplc_pkg::DIV_NUM_W'(lim_prod);
        div_den = cmd.cur_start ? cur_den : {1'b0, max_reg};
    end

    mplc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.lim_start | cmd.cur_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // quotient to target and to saturated current
    always_comb
    begin
        lim_q = $signed({3'b000, div_quo[14:0]});
        lim_val = tgt_sel[17] ? -lim_q : lim_q;
        pos_val = (div_quo > 34'd32767) ? 16'h7fff : div_quo[15:0];
        neg_mag = (div_quo > 34'd32768) ? 17'd32768 : div_quo[16:0];
        neg_full = 17'd0 - neg_mag;
        cur_val = err_sel[17] ? neg_full[15:0] : pos_val;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && cmd.in_ready)
        begin
            vel_x_reg <= in_ch.vel_x;
            vel_y_reg <= in_ch.vel_y;
            rot_z_reg <= in_ch.rot_z;
            speed_reg[0] <= in_ch.speed_lf;
            speed_reg[1] <= in_ch.speed_rf;
            speed_reg[2] <= in_ch.speed_rb;
            speed_reg[3] <= in_ch.speed_lb;
            power_reg <= in_ch.chassis_power;
            energy_reg <= in_ch.buffer_energy;
        end
        if (cmd.mix)
        begin
            tgt_reg <= mix_tgt;
            max_reg <= mix_max;
        end
        if (cmd.lim_store)
            tgt_reg[cmd.idx] <= lim_val;
        if (cmd.err)
        begin
            err_reg <= err_next;
            sum_reg <= sum_next;
        end
        if (cmd.mul)
            prod_reg <= 33'(err_mag_sel[15:0]) * 33'(current_budget_reg);
        if (cmd.out_load)
        begin
            out_cur_reg <= held_reg;
            out_held_reg <= cmd.hold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mplc_pkg::WHEELS; i++)
                held_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.zero_cur)
            begin
                for (int i = 0; i < mplc_pkg::WHEELS; i++)
                    held_reg[i] <= '0;
            end
            else if (cmd.cur_store)
                held_reg[cmd.idx] <= $signed(cur_val);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_ch.ready = cmd.in_ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.current_lf = out_cur_reg[0];
    assign out_ch.current_rf = out_cur_reg[1];
    assign out_ch.current_rb = out_cur_reg[2];
    assign out_ch.current_lb = out_cur_reg[3];
    assign out_ch.power_held = out_held_reg;

    always_comb
    begin
        sts.in_valid = in_ch.valid;
        sts.over_power = (power_reg > power_threshold_reg);
        sts.over_limit = (max_reg > 17'(speed_limit_reg));
        sts.sum_zero = (sum_reg == '0);
        sts.div_done = div_done;
        sts.out_free = !out_valid_reg || out_ch.ready;
    end

endmodule

// ===== rtl/core/mplc_ctrl.sv =====
// controller state machine sequencing mixing, limiting, current steps and result hand-off
// uses mplc_pkg command and status types
module mplc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  mplc_pkg::dp_sts_t sts,
    output mplc_pkg::dp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MIX      = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_LIM_GO   = 4'd3;
    localparam logic [3:0] S_LIM_WAIT = 4'd4;
    localparam logic [3:0] S_ERR      = 4'd5;
    localparam logic [3:0] S_SUM      = 4'd6;
    localparam logic [3:0] S_MUL      = 4'd7;
    localparam logic [3:0] S_CUR_GO   = 4'd8;
    localparam logic [3:0] S_CUR_WAIT = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0]                 state_reg, state_next;
    logic [mplc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       hold_reg, hold_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        hold_next = hold_reg;
        cmd = '0;
        cmd.idx = idx_reg;
        cmd.hold = hold_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                    state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                idx_next = '0;
                if (sts.over_power)
                begin
                    hold_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    hold_next = 1'b0;
                    state_next = sts.over_limit ? S_LIM_GO : S_ERR;
                end
            end
            S_LIM_GO:
            begin
                cmd.lim_start = 1'b1;
                state_next = S_LIM_WAIT;
            end
            S_LIM_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.lim_store = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg == '1) ? S_ERR : S_LIM_GO;
                end
            end
            S_ERR:
            begin
                cmd.err = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                idx_next = '0;
                if (sts.sum_zero)
                begin
                    cmd.zero_cur = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_CUR_GO;
            end
            S_CUR_GO:
            begin
                cmd.cur_start = 1'b1;
                state_next = S_CUR_WAIT;
            end
            S_CUR_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cur_store = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg == '1) ? S_OUT : S_MUL;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            hold_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            hold_reg <= hold_next;
        end
    end

`ifndef ASSERT_OFF
    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lim_start || cmd.cur_start) |=> !sts.div_done)
        else $error("divider done still set after start");
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");
    a_accept_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.in_ready && sts.in_valid) |=> (state_reg == S_MIX))
        else $error("accepted item not taken to mixing");
    a_store_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lim_store || cmd.cur_store) |-> sts.div_done)
        else $error("quotient stored before divider finished");
`endif

endmodule

// ===== rtl/core/mecanum_power_limited_current.sv =====
// top level of the mecanum power limited current block
// uses mplc_pkg, the channel interfaces, mplc_ctrl and mplc_datapath
//
// in_ch takes one item (chassis commands, wheel speeds, power, buffer energy) at a time;
// out_ch gives one item of four wheel currents and the power held flag for each input item.
// cfg_ch writes speed_limit, error_sum_limit, current_budget and power_threshold by index
// 0 to 3 and is always ready; write it only while the block is idle.
// when power is over threshold the held currents go out with the power held flag set;
// when the error sum is zero the currents are cleared; otherwise the current is scaled per
// wheel, and first the targets are scaled when they are over the speed limit.
// both steps use the shared 34-step restoring divider, once per wheel for the speed
// limit and once per wheel for the current.
// one item is in work at a time; in_ch.ready is high only between items.
// the result sits in an output register, so the next item is accepted while it waits;
// a stalled receiver holds the finished next result back until the register frees.
// reset puts the config registers to their defaults, clears the held currents and empties
// the output register.
module mecanum_power_limited_current (
    input  logic       clk,
    input  logic       rst_n,
    mplc_in_if.sink    in_ch,
    mplc_out_if.source out_ch,
    mplc_cfg_if.sink   cfg_ch
);

    mplc_pkg::dp_cmd_t cmd;
    mplc_pkg::dp_sts_t sts;

    mplc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    mplc_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule
